// ===== rtl/core/aesd_pkg.sv =====
package aesd_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int RK_IDX_W   = 4;
  localparam int CFG_IDX_W  = 8;

  typedef logic [RK_IDX_W-1:0]  rk_idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_UPPER = 8'd0;
  localparam cfg_idx_t REG_KEY_LOWER = 8'd1;

  localparam rk_idx_t LAST_RK  = 4'd10;
  localparam rk_idx_t FIRST_RK = 4'd0;

  // Control handed from the round sequencer to every column cell.
  typedef struct packed {
    logic load;  // take a new block, adding the last round key
    logic step;  // run one middle round
    logic mix;   // apply InvMixColumns after the key addition
  } cell_ctrl_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // InvMixColumns on one column; row 0 sits in the top byte.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    for (int r = 0; r < 4; r++) begin
      a[r]   = col[31-8*r -: 8];
      x2     = xtime(a[r]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[r]  = x8 ^ a[r];
      m11[r] = x8 ^ x2 ^ a[r];
      m13[r] = x8 ^ x4 ^ a[r];
      m14[r] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
  endfunction

endpackage

// ===== rtl/core/aesd_col_cell.sv =====
// One state column. Each round it takes the bytes its neighbors hand over
// (the InvShiftRows pattern), substitutes them, adds its key word and mixes when ctrl.mix is set.
module aesd_col_cell (
  input  logic                  clk,
  input  aesd_pkg::cell_ctrl_t  ctrl,
  input  logic [31:0]           load_col,
  input  logic [31:0]           shifted,
  input  logic [31:0]           rkey,
  output logic [31:0]           col,
  output logic [31:0]           step_col
);

  logic [31:0] sub_col;
  logic [31:0] keyed;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sub_col[31-8*r -: 8] = aesd_pkg::INV_SBOX[shifted[31-8*r -: 8]];
    end
    keyed    = sub_col ^ rkey;
    step_col = ctrl.mix ? aesd_pkg::inv_mix_col(keyed) : keyed;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      col <= load_col ^ rkey;
    end else if (ctrl.step) begin
      col <= step_col;
    end
  end

endmodule

// ===== rtl/core/aesd_key_sched.sv =====
// Holds the key registers and the eleven round keys. After reset or a key
// write the schedule is rebuilt, one round key per cycle while cfg_we is low.
module aesd_key_sched (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  aesd_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]         cfg_data,
  input  aesd_pkg::rk_idx_t   rd_idx,
  output logic [127:0]        rd_key,
  output logic                key_busy
);

  logic [63:0]        key_upper;
  logic [63:0]        key_lower;
  logic               exp_load;
  logic               exp_run;
  aesd_pkg::rk_idx_t  exp_idx;
  logic [7:0]         rcon;
  logic [127:0]       cur_key;
  logic [127:0]       key_next;
  logic [127:0]       rk [aesd_pkg::NUM_ROUNDS + 1];

  always_comb begin
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = {aesd_pkg::FWD_SBOX[cur_key[23:16]] ^ rcon,
          aesd_pkg::FWD_SBOX[cur_key[15:8]],
          aesd_pkg::FWD_SBOX[cur_key[7:0]],
          aesd_pkg::FWD_SBOX[cur_key[31:24]]};
    w0 = cur_key[127:96] ^ t;
    w1 = cur_key[95:64] ^ w0;
    w2 = cur_key[63:32] ^ w1;
    w3 = cur_key[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
      exp_load  <= 1'b1;
      exp_run   <= 1'b0;
      exp_idx   <= '0;
      rcon      <= 8'h01;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          aesd_pkg::REG_KEY_UPPER: begin
            key_upper <= cfg_data;
            exp_load  <= 1'b1;
            exp_run   <= 1'b0;
          end
          aesd_pkg::REG_KEY_LOWER: begin
            key_lower <= cfg_data;
            exp_load  <= 1'b1;
            exp_run   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (exp_load && !cfg_we) begin
        exp_load <= 1'b0;
        exp_run  <= 1'b1;
        exp_idx  <= aesd_pkg::rk_idx_t'(1);
        rcon     <= 8'h01;
      end else if (exp_run && !cfg_we) begin
        exp_idx <= exp_idx + aesd_pkg::rk_idx_t'(1);
        rcon    <= aesd_pkg::xtime(rcon);
        if (exp_idx == aesd_pkg::LAST_RK) begin
          exp_run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exp_load) begin
      cur_key <= {key_upper, key_lower};
      rk[0]   <= {key_upper, key_lower};
    end else if (exp_run) begin
      cur_key     <= key_next;
      rk[exp_idx] <= key_next;
    end
  end

  assign rd_key   = rk[rd_idx];
  assign key_busy = exp_load | exp_run;

endmodule

// ===== rtl/core/aes128_block_decrypt_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: cipher_upper, cipher_lower
// m_*       out  m_tvalid/m_tready  m_tdata: plain_upper, plain_lower
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (key halves)
//
// A block runs in steps: the cycle it is accepted adds round key 10, the nine
// middle rounds follow with keys 9 down to 1, and a final round adds key 0
// into the output register. The four column cells are the round unit.
// After reset, and after every write to a key register, the round keys are
// rebuilt while s_tready stays low. A stalled result waits in the output
// register; a new block is accepted meanwhile and holds in its final round.
module aes128_block_decrypt_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [63:0] cipher_upper, [127:64] cipher_lower
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [63:0] plain_upper, [127:64] plain_lower
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic                  busy;
  aesd_pkg::rk_idx_t     rnd;
  logic                  key_busy;
  logic                  accept;
  logic                  out_free;
  aesd_pkg::rk_idx_t     rk_sel;
  logic [127:0]          rkey;
  logic [127:0]          in_word;
  aesd_pkg::cell_ctrl_t  ctrl;
  logic [31:0]           cols [4];
  logic [31:0]           step_cols [4];

  // Key writes are always taken; the schedule restarts on each key-register write.
  assign cfg_ready = 1'b1;

  aesd_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (rk_sel),
    .rd_key    (rkey),
    .key_busy  (key_busy)
  );

  assign s_tready = !busy && !key_busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rk_sel   = busy ? rnd : aesd_pkg::LAST_RK;
  // Byte 0 of the state is the top byte of cipher_upper.
  assign in_word  = {s_tdata[63:0], s_tdata[127:64]};

  always_comb begin
    ctrl.load = accept;
    ctrl.step = busy && (rnd != aesd_pkg::FIRST_RK);
    ctrl.mix  = rnd != aesd_pkg::FIRST_RK;
  end

  // The cells form a ring: cell c takes row r from cell (c - r) mod 4.
  for (genvar c = 0; c < 4; c++) begin : g_cell
    aesd_col_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_col (in_word[127-32*c -: 32]),
      .shifted  ({cols[c][31:24], cols[(c+3)%4][23:16],
                  cols[(c+2)%4][15:8], cols[(c+1)%4][7:0]}),
      .rkey     (rkey[127-32*c -: 32]),
      .col      (cols[c]),
      .step_col (step_cols[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rnd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        rnd  <= aesd_pkg::LAST_RK - aesd_pkg::rk_idx_t'(1);
      end else if (busy) begin
        if (rnd != aesd_pkg::FIRST_RK) begin
          rnd <= rnd - aesd_pkg::rk_idx_t'(1);
        end else if (out_free) begin
          busy     <= 1'b0;
          m_tvalid <= 1'b1;
        end
      end
    end
  end

  // Final round lands straight in the output register.
  always_ff @(posedge clk) begin
    if (busy && (rnd == aesd_pkg::FIRST_RK) && out_free) begin
      m_tdata <= {step_cols[2], step_cols[3], step_cols[0], step_cols[1]};
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [63:0]  cfg_data;

  aes128_block_decrypt_unit DUT (.*);

  // Predictor state: the key registers and their expansion.
  logic [63:0]  key_hi_q;
  logic [63:0]  key_lo_q;
  logic [127:0] sched [11];
  logic [7:0]   inv_box [256];

  block_t cipher_queue[$];
  block_t plain_queue[$];
  int     errors;
  int     plain_seen;
  int     cipher_sent;
  int     keys_used;
  int     idle_cycles;
  bit     no_idle;
  bit     hold_sink;
  int     sink_hold_left;
  bit     src_fire;

  function automatic logic [7:0] gf2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] m);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) acc ^= a;
      a = gf2(a);
    end
    return acc;
  endfunction

  // Byte n of a 128-bit block sits at bits [127-8n -: 8].
  task automatic rebuild_schedule();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] rc;
    logic [7:0] first;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i]     = key_hi_q[63-8*i -: 8];
      w[8 + i] = key_lo_q[63-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[4*(i-1) + j];
      if (i % 4 == 0) begin
        first = t[0];
        t[0] = aesd_pkg::FWD_SBOX[t[1]] ^ rc;
        t[1] = aesd_pkg::FWD_SBOX[t[2]];
        t[2] = aesd_pkg::FWD_SBOX[t[3]];
        t[3] = aesd_pkg::FWD_SBOX[first];
        rc = gf2(rc);
      end
      for (int j = 0; j < 4; j++) w[4*i + j] = w[4*(i-4) + j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int n = 0; n < 16; n++) sched[r][127-8*n -: 8] = w[16*r + n];
  endtask

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = inv_box[s[127-8*(4*((c+4-r)%4)+r) -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a, b, d, e;
    for (int c = 0; c < 4; c++) begin
      a = s[127-32*c -: 8];
      b = s[119-32*c -: 8];
      d = s[111-32*c -: 8];
      e = s[103-32*c -: 8];
      o[127-32*c -: 8] = gfmul(a,8'd14) ^ gfmul(b,8'd11) ^ gfmul(d,8'd13) ^ gfmul(e,8'd9);
      o[119-32*c -: 8] = gfmul(a,8'd9)  ^ gfmul(b,8'd14) ^ gfmul(d,8'd11) ^ gfmul(e,8'd13);
      o[111-32*c -: 8] = gfmul(a,8'd13) ^ gfmul(b,8'd9)  ^ gfmul(d,8'd14) ^ gfmul(e,8'd11);
      o[103-32*c -: 8] = gfmul(a,8'd11) ^ gfmul(b,8'd13) ^ gfmul(d,8'd9)  ^ gfmul(e,8'd14);
    end
    return o;
  endfunction

  function automatic block_t decrypt_block(input block_t c);
    logic [127:0] s;
    block_t p;
    s = {c.hi, c.lo} ^ sched[10];
    s = unshift_unsub(s);
    for (int r = 9; r >= 1; r--) s = unshift_unsub(unmix(s ^ sched[r]));
    s ^= sched[0];
    p.hi = s[127:64];
    p.lo = s[63:0];
    return p;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Source side: random gaps, except in the no-idle phase. A new item is
  // offered only once the current one was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || src_fire) begin
      if (cipher_queue.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {cipher_queue[0].lo, cipher_queue[0].hi};
        void'(cipher_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      m_tready <= 1'b0;
      sink_hold_left <= sink_hold_left - 1;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
      sink_hold_left <= 300;
      hold_sink <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Input acceptance computes the expected plaintext with the current key;
  // output acceptance checks it.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      src_fire    <= 1'b0;
    end else begin
      src_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        plain_queue.push_back(decrypt_block('{hi: s_tdata[63:0], lo: s_tdata[127:64]}));
        cipher_sent++;
      end
      if (m_tvalid && m_tready) begin
        plain_seen++;
        if (plain_queue.size() == 0) begin
          report("unexpected plain_upper", m_tdata[63:0], '0);
        end else begin
          if (m_tdata[63:0] !== plain_queue[0].hi)
            report("plain_upper", m_tdata[63:0], plain_queue[0].hi);
          if (m_tdata[127:64] !== plain_queue[0].lo)
            report("plain_lower", m_tdata[127:64], plain_queue[0].lo);
          void'(plain_queue.pop_front());
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_block(input logic [63:0] hi, input logic [63:0] lo);
    cipher_queue.push_back('{hi: hi, lo: lo});
  endtask

  task automatic drain();
    while (cipher_queue.size() > 0 || s_tvalid || plain_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input aesd_pkg::cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == aesd_pkg::REG_KEY_UPPER) key_hi_q = val;
    else if (idx == aesd_pkg::REG_KEY_LOWER) key_lo_q = val;
    rebuild_schedule();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_blocks(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      case (kind)
        0:       push_block('0, rand64());
        1:       push_block(rand64(), '1);
        default: push_block(rand64(), rand64());
      endcase
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = aesd_pkg::REG_KEY_UPPER;
    cfg_data = '0;
    errors = 0;
    plain_seen = 0;
    cipher_sent = 0;
    keys_used = 1;
    no_idle = 1'b0;
    hold_sink = 1'b0;
    sink_hold_left = 0;
    for (int i = 0; i < 256; i++) inv_box[aesd_pkg::FWD_SBOX[i]] = i[7:0];
    key_hi_q = '0;
    key_lo_q = '0;
    rebuild_schedule();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset key, field extremes, then the standard test vector key.
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'h8000000000000000, 64'h0000000000000001);
    push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(aesd_pkg::REG_KEY_UPPER, 64'h0001020304050607);
    write_key(aesd_pkg::REG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
    keys_used++;
    push_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    push_block('0, '1);
    push_block('1, '0);
    drain();
    // An unknown index must leave the key untouched.
    write_key(8'd2, '1);
    write_key(8'hff, 64'h1234);
    push_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    drain();
    write_key(aesd_pkg::REG_KEY_UPPER, '1);
    write_key(aesd_pkg::REG_KEY_LOWER, '1);
    keys_used++;
    push_block('0, '0);
    push_block('1, '1);
    drain();

    // Random phases, each with a new key; one phase without idling and one
    // with a long sink stall while the source keeps offering blocks.
    for (int ph = 0; ph < 8; ph++) begin
      write_key(aesd_pkg::REG_KEY_UPPER, rand64());
      write_key(aesd_pkg::REG_KEY_LOWER, rand64());
      keys_used++;
      no_idle = (ph == 2);
      if (ph == 4) hold_sink = 1'b1;
      random_blocks(140);
      drain();
    end
    no_idle = 1'b0;

    $display("Decrypted %0d blocks (%0d checked) under %0d cipher keys,", cipher_sent,
             plain_seen, keys_used);
    $display("including extreme keys and blocks, ignored writes and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/aesd_pkg.sv
rtl/core/aesd_col_cell.sv
rtl/core/aesd_key_sched.sv
rtl/core/aes128_block_decrypt_unit.sv
test/tb.sv
